// ===== rtl/core/alle_pkg.sv =====
// Shared types and constants of the array based linked list engine.
package alle_pkg;

   localparam int ALLE_SLOTS       = 32;
   localparam int ALLE_VALUE_WIDTH = 16;

   // Link, position and count fields are fixed at six bits; all ones ends the list.
   localparam int LINK_W   = 6;
   localparam int POS_W    = 6;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   localparam logic [LINK_W-1:0] END_MARK = '1;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_GET    = 2'd2;

   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_RANGE = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_WALK,
      S_STEP,
      S_FETCHED,
      S_LINK,
      S_INS_HEAD,
      S_VDONE
   } state_type;

endpackage

// ===== rtl/core/alle_chan_if.sv =====
// Request and response channel interfaces of the linked list engine.
interface alle_req_if
   import alle_pkg::*;
   #(parameter int VALUE_WIDTH = ALLE_VALUE_WIDTH);

   logic                          valid;
   logic                          ready;
   cmd_type                       cmd;
   logic [POS_W-1:0]              position;
   logic signed [VALUE_WIDTH-1:0] value_in;

   modport source (output valid, output cmd, output position, output value_in, input ready);
   modport sink   (input valid, input cmd, input position, input value_in, output ready);

endinterface

interface alle_rsp_if
   import alle_pkg::*;
   #(parameter int VALUE_WIDTH = ALLE_VALUE_WIDTH);

   logic                          valid;
   logic                          ready;
   status_type                    status;
   logic signed [VALUE_WIDTH-1:0] value_out;

   modport source (output valid, output status, output value_out, input ready);
   modport sink   (input valid, input status, input value_out, output ready);

endinterface

// ===== rtl/core/array_linked_list_engine_core.sv =====
// Linked list engine: a singly linked list kept in a table of slots, one response per request.
//
// The list lives in two small memories (value and next link per slot) plus a used bit per slot,
// a head pointer and a node count. A request inserts a value so that it becomes node number
// position, deletes node number position, or reads node number position. The engine handles
// one request at a time and drops ready until its response is registered. An error (position
// out of range, unknown command, or insert into a full table) is answered in the cycle after
// the request is taken and changes nothing. Otherwise the time is set by the link walk: each
// hop through the next-link memory passes the walk and step states because its read data is
// registered. An insert first scans the used bits, one slot per cycle, up to the lowest free
// slot. The response waits in an output register; a new request is taken only once the
// previous response leaves, or in the same cycle.
module array_linked_list_engine_core
   import alle_pkg::*;
   #(
      parameter int SLOTS       = ALLE_SLOTS,
      parameter int VALUE_WIDTH = ALLE_VALUE_WIDTH
   )
   (
      input logic         clock,
      input logic         reset,
      alle_req_if.sink    req_chan,
      alle_rsp_if.source  rsp_chan
   );

   localparam int SLOT_W = $clog2(SLOTS);

   // Slot table memories. Contents are only used after being written by an insert.
   logic [VALUE_WIDTH-1:0] value_mem [SLOTS];
   logic [LINK_W-1:0]      next_mem  [SLOTS];

   state_type              state_ff,      state_in;
   cmd_type                cmd_ff,        cmd_in;
   logic [POS_W-1:0]       pos_ff,        pos_in;
   logic [VALUE_WIDTH-1:0] val_ff,        val_in;
   logic [SLOT_W-1:0]      cur_ff,        cur_in;
   logic [POS_W-1:0]       rem_ff,        rem_in;
   logic [SLOT_W-1:0]      scan_ff,       scan_in;
   logic [SLOT_W-1:0]      fr_ff,         fr_in;
   logic [SLOT_W-1:0]      vic_ff,        vic_in;
   logic [LINK_W-1:0]      head_ff,       head_in;
   logic [POS_W-1:0]       count_ff,      count_in;
   logic [SLOTS-1:0]       used_ff,       used_in;
   logic                   rsp_valid_ff,  rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff,  rsp_value_in;

   // Registered read data of both memories, addressed by rd_addr.
   logic [LINK_W-1:0]      rd_next_ff;
   logic [VALUE_WIDTH-1:0] rd_value_ff;

   logic [SLOT_W-1:0]      rd_addr;
   logic                   nx_we;
   logic [SLOT_W-1:0]      nx_waddr;
   logic [LINK_W-1:0]      nx_wdata;
   logic                   vl_we;

   logic                   req_ready;
   logic                   req_take;
   logic [POS_W:0]         ins_limit;
   logic                   ins_ok;
   logic                   acc_ok;

   assign req_ready      = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take       = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.value_out = rsp_value_ff;

   // An insert may name any position from the head up to one past the tail.
   assign ins_limit = {1'b0, count_ff} + (POS_W+1)'(1);
   assign ins_ok    = (req_chan.position != '0) && ({1'b0, req_chan.position} <= ins_limit);
   assign acc_ok    = (req_chan.position != '0) && (req_chan.position <= count_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      scan_in       = scan_ff;
      fr_in         = fr_ff;
      vic_in        = vic_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rd_addr       = cur_ff;
      nx_we         = 1'b0;
      nx_waddr      = fr_ff;
      nx_wdata      = rd_next_ff;
      vl_we         = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in        = req_chan.cmd;
               pos_in        = req_chan.position;
               val_in        = req_chan.value_in;
               cur_in        = head_ff[SLOT_W-1:0];
               // Errors are answered at once and leave the table untouched.
               rsp_status_in = STATUS_RANGE;
               rsp_value_in  = '0;
               case (req_chan.cmd)
                  CMD_INSERT: begin
                     if (!ins_ok) begin
                        rsp_valid_in = 1'b1;
                     end else if (count_ff == POS_W'(SLOTS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        scan_in  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_DELETE: begin
                     if (!acc_ok) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        // Deleting the head fetches the head itself, else its predecessor.
                        rem_in   = (req_chan.position == POS_W'(1)) ? '0
                                   : req_chan.position - POS_W'(2);
                        state_in = S_WALK;
                     end
                  end
                  CMD_GET: begin
                     if (!acc_ok) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rem_in   = req_chan.position - POS_W'(1);
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // One used bit per cycle; a free slot is known to exist.
            if (!used_ff[scan_ff]) begin
               fr_in = scan_ff;
               if (pos_ff == POS_W'(1)) begin
                  state_in = S_INS_HEAD;
               end else begin
                  cur_in   = head_ff[SLOT_W-1:0];
                  rem_in   = pos_ff - POS_W'(2);
                  state_in = S_WALK;
               end
            end else begin
               scan_in = scan_ff + SLOT_W'(1);
            end
         end

         S_WALK: begin
            rd_addr = cur_ff;
            if (rem_ff == '0) begin
               state_in = S_FETCHED;
            end else begin
               state_in = S_STEP;
            end
         end

         S_STEP: begin
            cur_in   = rd_next_ff[SLOT_W-1:0];
            rem_in   = rem_ff - POS_W'(1);
            state_in = S_WALK;
         end

         S_FETCHED: begin
            // rd_next_ff and rd_value_ff now belong to slot cur_ff.
            case (cmd_ff)
               CMD_GET: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_DONE;
                  rsp_value_in  = rd_value_ff;
                  state_in      = S_IDLE;
               end
               CMD_INSERT: begin
                  // New node takes over the predecessor's successor.
                  vl_we    = 1'b1;
                  nx_we    = 1'b1;
                  nx_waddr = fr_ff;
                  nx_wdata = rd_next_ff;
                  state_in = S_LINK;
               end
               CMD_DELETE: begin
                  if (pos_ff == POS_W'(1)) begin
                     head_in          = rd_next_ff;
                     used_in[cur_ff]  = 1'b0;
                     count_in         = count_ff - POS_W'(1);
                     rsp_valid_in     = 1'b1;
                     rsp_status_in    = STATUS_DONE;
                     rsp_value_in     = rd_value_ff;
                     state_in         = S_IDLE;
                  end else begin
                     vic_in   = rd_next_ff[SLOT_W-1:0];
                     rd_addr  = rd_next_ff[SLOT_W-1:0];
                     state_in = S_VDONE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_LINK: begin
            nx_we           = 1'b1;
            nx_waddr        = cur_ff;
            nx_wdata        = LINK_W'(fr_ff);
            used_in[fr_ff]  = 1'b1;
            count_in        = count_ff + POS_W'(1);
            rsp_valid_in    = 1'b1;
            rsp_status_in   = STATUS_DONE;
            rsp_value_in    = '0;
            state_in        = S_IDLE;
         end

         S_INS_HEAD: begin
            vl_we           = 1'b1;
            nx_we           = 1'b1;
            nx_waddr        = fr_ff;
            nx_wdata        = head_ff;
            head_in         = LINK_W'(fr_ff);
            used_in[fr_ff]  = 1'b1;
            count_in        = count_ff + POS_W'(1);
            rsp_valid_in    = 1'b1;
            rsp_status_in   = STATUS_DONE;
            rsp_value_in    = '0;
            state_in        = S_IDLE;
         end

         S_VDONE: begin
            // Read data is the victim's; bypass it in the predecessor's link.
            nx_we           = 1'b1;
            nx_waddr        = cur_ff;
            nx_wdata        = rd_next_ff;
            used_in[vic_ff] = 1'b0;
            count_in        = count_ff - POS_W'(1);
            rsp_valid_in    = 1'b1;
            rsp_status_in   = STATUS_DONE;
            rsp_value_in    = rd_value_ff;
            state_in        = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= END_MARK;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      rem_ff        <= rem_in;
      scan_ff       <= scan_in;
      fr_ff         <= fr_in;
      vic_ff        <= vic_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (nx_we) begin
         next_mem[nx_waddr] <= nx_wdata;
      end
      if (vl_we) begin
         value_mem[fr_ff] <= val_ff;
      end
      rd_next_ff  <= next_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

endmodule
